FILE: hw/rtl/modexp_pkg.sv
// Package for the modular exponentiation block: payload widths, microcode
// opcodes, jump conditions, step addresses and the control store.
// Depends on nothing; used by modular_exponentiation.
package modexp_pkg;

  // Fixed payload widths of the data channels.
  localparam int BASE_W = 16;
  localparam int RES_W  = 16;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 4'd1;

  // Program counter and control store size.
  localparam int PC_W = 4;

  // Datapath operations.
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_RED_SETUP = 4'd1;  // reduce base: a = 1, b = base
  localparam logic [3:0] OP_DBL       = 4'd2;  // acc = 2*acc mod m
  localparam logic [3:0] OP_ADD       = 4'd3;  // acc += a if b msb, shift b
  localparam logic [3:0] OP_RED_DONE  = 4'd4;  // keep reduced base, x = 1
  localparam logic [3:0] OP_SQ_SETUP  = 4'd5;  // a = x, b = x
  localparam logic [3:0] OP_TAKE_X    = 4'd6;  // x = acc
  localparam logic [3:0] OP_ML_SETUP  = 4'd7;  // a = base, b = x
  localparam logic [3:0] OP_NEXT_BIT  = 4'd8;  // move to next exponent bit
  localparam logic [3:0] OP_FINISH    = 4'd9;  // load the output register

  // Jump conditions.
  localparam logic [2:0] COND_NEVER     = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_NO_INPUT  = 3'd2;
  localparam logic [2:0] COND_CNT_MORE  = 3'd3;
  localparam logic [2:0] COND_EBIT_ZERO = 3'd4;
  localparam logic [2:0] COND_ECNT_MORE = 3'd5;
  localparam logic [2:0] COND_OUT_BUSY  = 3'd6;

  // Step addresses.
  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] STEP_RED_SETUP = 4'd1;
  localparam logic [PC_W-1:0] STEP_RED_DBL   = 4'd2;
  localparam logic [PC_W-1:0] STEP_RED_ADD   = 4'd3;
  localparam logic [PC_W-1:0] STEP_RED_DONE  = 4'd4;
  localparam logic [PC_W-1:0] STEP_SQ_SETUP  = 4'd5;
  localparam logic [PC_W-1:0] STEP_SQ_DBL    = 4'd6;
  localparam logic [PC_W-1:0] STEP_SQ_ADD    = 4'd7;
  localparam logic [PC_W-1:0] STEP_SQ_DONE   = 4'd8;
  localparam logic [PC_W-1:0] STEP_ML_SETUP  = 4'd9;
  localparam logic [PC_W-1:0] STEP_ML_DBL    = 4'd10;
  localparam logic [PC_W-1:0] STEP_ML_ADD    = 4'd11;
  localparam logic [PC_W-1:0] STEP_ML_DONE   = 4'd12;
  localparam logic [PC_W-1:0] STEP_NEXT_BIT  = 4'd13;
  localparam logic [PC_W-1:0] STEP_FINISH    = 4'd14;
  localparam logic [PC_W-1:0] STEP_RETURN    = 4'd15;

  // One control word: operation, jump condition and jump target.
  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Control store. When the condition holds the sequencer jumps to the
  // target, otherwise it falls through to the next step.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      STEP_IDLE:      w = '{OP_NOP,       COND_NO_INPUT,  STEP_IDLE};
      STEP_RED_SETUP: w = '{OP_RED_SETUP, COND_NEVER,     STEP_IDLE};
      STEP_RED_DBL:   w = '{OP_DBL,       COND_NEVER,     STEP_IDLE};
      STEP_RED_ADD:   w = '{OP_ADD,       COND_CNT_MORE,  STEP_RED_DBL};
      STEP_RED_DONE:  w = '{OP_RED_DONE,  COND_NEVER,     STEP_IDLE};
      STEP_SQ_SETUP:  w = '{OP_SQ_SETUP,  COND_NEVER,     STEP_IDLE};
      STEP_SQ_DBL:    w = '{OP_DBL,       COND_NEVER,     STEP_IDLE};
      STEP_SQ_ADD:    w = '{OP_ADD,       COND_CNT_MORE,  STEP_SQ_DBL};
      STEP_SQ_DONE:   w = '{OP_TAKE_X,    COND_EBIT_ZERO, STEP_NEXT_BIT};
      STEP_ML_SETUP:  w = '{OP_ML_SETUP,  COND_NEVER,     STEP_IDLE};
      STEP_ML_DBL:    w = '{OP_DBL,       COND_NEVER,     STEP_IDLE};
      STEP_ML_ADD:    w = '{OP_ADD,       COND_CNT_MORE,  STEP_ML_DBL};
      STEP_ML_DONE:   w = '{OP_TAKE_X,    COND_NEVER,     STEP_IDLE};
      STEP_NEXT_BIT:  w = '{OP_NEXT_BIT,  COND_ECNT_MORE, STEP_SQ_SETUP};
      STEP_FINISH:    w = '{OP_FINISH,    COND_OUT_BUSY,  STEP_FINISH};
      STEP_RETURN:    w = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
      default:        w = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: a microcoded sequencer
// driving a shift-and-add modular multiplier. Depends on modexp_pkg.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    base_value
//   out      source     out_valid / out_stall  power_result
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted item runs the reduction of the base, then for each exponent bit
// a squaring, a multiply by the reduced base where that bit is set and the
// step to the next bit, then the step that loads the output register, and
// returns to idle before the next beat is taken. Each multiplier bit takes a
// double step and an add step. Reset returns the sequencer to idle, empties the output
// register and loads modulus 2 and exponent 0. A stalled result is held while
// the next beat is worked on; the last step waits only if it is still unread.
module modular_exponentiation #(
  parameter int MOD_WIDTH = 16,
  parameter int EXP_BITS  = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [modexp_pkg::BASE_W-1:0]          base_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [modexp_pkg::RES_W-1:0]           power_result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [modexp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [(MOD_WIDTH > EXP_BITS ? MOD_WIDTH : EXP_BITS)-1:0] cfg_data
);
  import modexp_pkg::*;

  // The multiplier operand register must hold either a reduced value or
  // the raw base, whichever is wider.
  localparam int OPW    = (MOD_WIDTH > BASE_W) ? MOD_WIDTH : BASE_W;
  localparam int CNT_W  = $clog2(OPW + 1);
  localparam int ECNT_W = $clog2(EXP_BITS + 1);

  // Configuration registers.
  logic [MOD_WIDTH-1:0] modulus;
  logic [EXP_BITS-1:0]  secret_exponent;

  // Sequencer.
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            jump;

  // Datapath registers.
  logic [BASE_W-1:0]    base_in;   // captured input beat
  logic [MOD_WIDTH-1:0] base_red;  // base reduced modulo the modulus
  logic [MOD_WIDTH-1:0] x;         // running power
  logic [MOD_WIDTH-1:0] a;         // multiplicand
  logic [OPW-1:0]       b;         // multiplier, consumed from the top
  logic [MOD_WIDTH-1:0] acc;       // product accumulator
  logic [CNT_W-1:0]     cnt;       // multiplier bits left
  logic [EXP_BITS-1:0]  e;         // exponent, consumed from the top
  logic [ECNT_W-1:0]    ecnt;      // exponent bits left

  logic                 in_accept;
  logic                 out_free;
  logic [MOD_WIDTH-1:0] dbl_val;
  logic [MOD_WIDTH-1:0] add_val;

  // (p + q) mod m for p, q below m: one add, one compare, one subtract.
  function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] p,
                                                   input logic [MOD_WIDTH-1:0] q,
                                                   input logic [MOD_WIDTH-1:0] m);
    logic [MOD_WIDTH:0] s;
    s = {1'b0, p} + {1'b0, q};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_WIDTH-1:0];
  endfunction

  // New beats are taken only at the idle step; the output register keeps
  // a finished result independently of that.
  assign in_stall  = (pc != STEP_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign uw      = ucode_rom(pc);
  assign dbl_val = add_mod(acc, acc, modulus);
  assign add_val = add_mod(acc, a, modulus);

  always_comb begin
    case (uw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !in_accept;
      COND_CNT_MORE:  jump = (cnt != CNT_W'(1));
      COND_EBIT_ZERO: jump = !e[EXP_BITS-1];
      COND_ECNT_MORE: jump = (ecnt != ECNT_W'(1));
      COND_OUT_BUSY:  jump = !out_free;
      default:        jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= MOD_WIDTH'(2);
      secret_exponent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MODULUS) begin
        modulus <= cfg_data[MOD_WIDTH-1:0];
      end else if (cfg_index == REG_EXPONENT) begin
        secret_exponent <= cfg_data[EXP_BITS-1:0];
      end
    end
  end

  // Datapath. The base is reduced by running the multiplier with a
  // multiplicand of one over the raw base bits, so no divider is needed.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      base_in <= base_value;
    end
    case (uw.op)
      OP_RED_SETUP: begin
        a   <= MOD_WIDTH'(1);
        b   <= OPW'(base_in) << (OPW - BASE_W);
        acc <= '0;
        cnt <= CNT_W'(BASE_W);
      end
      OP_DBL: begin
        acc <= dbl_val;
      end
      OP_ADD: begin
        if (b[OPW-1]) begin
          acc <= add_val;
        end
        b   <= b << 1;
        cnt <= cnt - CNT_W'(1);
      end
      OP_RED_DONE: begin
        base_red <= acc;
        x        <= MOD_WIDTH'(1);
        e        <= secret_exponent;
        ecnt     <= ECNT_W'(EXP_BITS);
      end
      OP_SQ_SETUP: begin
        a   <= x;
        b   <= OPW'(x) << (OPW - MOD_WIDTH);
        acc <= '0;
        cnt <= CNT_W'(MOD_WIDTH);
      end
      OP_TAKE_X: begin
        x <= acc;
      end
      OP_ML_SETUP: begin
        a   <= base_red;
        b   <= OPW'(x) << (OPW - MOD_WIDTH);
        acc <= '0;
        cnt <= CNT_W'(MOD_WIDTH);
      end
      OP_NEXT_BIT: begin
        e    <= e << 1;
        ecnt <= ecnt - ECNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register. A modulus of zero or one gives zero; the datapath
  // runs regardless and its value is discarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == OP_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_FINISH && out_free) begin
      power_result <= (modulus <= MOD_WIDTH'(1)) ? '0 : RES_W'(x);
    end
  end

  // An accepted beat always starts the program at the reduction step.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> pc == STEP_RED_SETUP)
    else $error("accepted beat did not start the program");

  // Multiplier loops never run with an exhausted bit counter.
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_RED_DBL || pc == STEP_RED_ADD || pc == STEP_SQ_DBL ||
     pc == STEP_SQ_ADD || pc == STEP_ML_DBL || pc == STEP_ML_ADD) |-> cnt != '0)
    else $error("multiplier step with zero bit count");

  // A delivered power is always reduced below a real modulus.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_FINISH && out_free && modulus >= MOD_WIDTH'(2)) |-> x < modulus)
    else $error("result not reduced below modulus");

endmodule
